### rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, codes and item types of the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int CoordBits = 16;
	localparam int DiffBits  = CoordBits + 1;
	localparam int MagBits   = CoordBits;
	localparam int PixBits   = 12;
	localparam int WinBits   = 13;
	localparam int ColorBits = 32;

	localparam int FracBits  = 16;
	localparam int CmdDepth  = 4;
	localparam int ResDepth  = 2;

	localparam logic [WinBits-1:0] PixLimit    = 13'd4096;
	localparam logic [WinBits-1:0] WidthReset  = 13'd1024;
	localparam logic [WinBits-1:0] HeightReset = 13'd768;

	localparam logic OpStart = 1'b0;
	localparam logic OpTick  = 1'b1;

	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	typedef struct packed {
		logic                        opcode;
		logic signed [CoordBits-1:0] start_x;
		logic signed [CoordBits-1:0] start_y;
		logic signed [CoordBits-1:0] end_x;
		logic signed [CoordBits-1:0] end_y;
		logic [ColorBits-1:0]        color;
	} cmd_t;

	typedef struct packed {
		logic [PixBits-1:0]   pixel_x;
		logic [PixBits-1:0]   pixel_y;
		logic [ColorBits-1:0] pixel_color;
		logic                 write_pixel;
		logic                 last_point;
		logic                 line_idle;
	} res_t;

	// Classified item handed from the front end to the back end.
	typedef struct packed {
		logic                        op;
		logic signed [CoordBits-1:0] sx;
		logic signed [CoordBits-1:0] sy;
		logic                        neg_x;
		logic                        neg_y;
		logic [MagBits-1:0]          mag_x;
		logic [MagBits-1:0]          mag_y;
		logic [MagBits-1:0]          steps;
		logic [ColorBits-1:0]        color;
	} entry_t;

endpackage

### rtl/dda_fifo.sv
// ----------------------------------------------------------------------------
// DDA item queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module dda_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] data_in,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] data_out
);

	localparam int PtrBits = $clog2(DEPTH);
	localparam int CntBits = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]   mem_q [DEPTH];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [CntBits-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (cnt_q == CntBits'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

endmodule

### rtl/dda_front.sv
// ----------------------------------------------------------------------------
// DDA front end
// Takes items, forms the endpoint differences and classifies each line.
// ----------------------------------------------------------------------------
module dda_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  dda_pkg::cmd_t   cmd,
	input  logic            q_full,
	output logic            q_push,
	output dda_pkg::entry_t q_data
);

	logic                                 valid_s1;
	logic                                 op_s1;
	logic signed [dda_pkg::CoordBits-1:0] sx_s1;
	logic signed [dda_pkg::CoordBits-1:0] sy_s1;
	logic signed [dda_pkg::DiffBits-1:0]  dx_s1;
	logic signed [dda_pkg::DiffBits-1:0]  dy_s1;
	logic [dda_pkg::ColorBits-1:0]        color_s1;
	logic                                 adv;
	logic signed [dda_pkg::DiffBits-1:0]  abs_x;
	logic signed [dda_pkg::DiffBits-1:0]  abs_y;
	logic [dda_pkg::MagBits-1:0]          mag_x;
	logic [dda_pkg::MagBits-1:0]          mag_y;

	assign adv    = !valid_s1 || !q_full;
	assign full   = !adv;
	assign q_push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			op_s1    <= cmd.opcode;
			sx_s1    <= cmd.start_x;
			sy_s1    <= cmd.start_y;
			dx_s1    <= dda_pkg::DiffBits'(cmd.end_x) - dda_pkg::DiffBits'(cmd.start_x);
			dy_s1    <= dda_pkg::DiffBits'(cmd.end_y) - dda_pkg::DiffBits'(cmd.start_y);
			color_s1 <= cmd.color;
		end
	end

	// The magnitudes never exceed 2^16 - 1, so they fit MagBits.
	assign abs_x = dx_s1[dda_pkg::DiffBits-1] ? -dx_s1 : dx_s1;
	assign abs_y = dy_s1[dda_pkg::DiffBits-1] ? -dy_s1 : dy_s1;
	assign mag_x = abs_x[dda_pkg::MagBits-1:0];
	assign mag_y = abs_y[dda_pkg::MagBits-1:0];

	always_comb begin
		q_data.op    = op_s1;
		q_data.sx    = sx_s1;
		q_data.sy    = sy_s1;
		q_data.neg_x = dx_s1[dda_pkg::DiffBits-1];
		q_data.neg_y = dy_s1[dda_pkg::DiffBits-1];
		q_data.mag_x = mag_x;
		q_data.mag_y = mag_y;
		q_data.steps = (mag_x > mag_y) ? mag_x : mag_y;
		q_data.color = color_s1;
	end

endmodule

### rtl/dda_div.sv
// ----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider giving round(mag * 2^FRAC_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
module dda_div #(
	parameter int FRAC_BITS = dda_pkg::FracBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dda_pkg::MagBits-1:0] mag,
	input  logic [dda_pkg::MagBits-1:0] den_in,
	output logic                        busy,
	output logic [FRAC_BITS:0]          quo
);

	localparam int QuoBits = FRAC_BITS + 1;
	localparam int NumBits = dda_pkg::MagBits + QuoBits;
	localparam int CntBits = $clog2(QuoBits + 1);

	logic                          busy_q;
	logic [CntBits-1:0]            cnt_q;
	logic [dda_pkg::MagBits-1:0]   rem_q;
	logic [QuoBits-1:0]            num_q;
	logic [dda_pkg::MagBits-1:0]   den_q;
	logic [QuoBits-1:0]            quo_q;
	logic [NumBits-1:0]            num_full;
	logic [dda_pkg::MagBits:0]     trial;
	logic [dda_pkg::MagBits:0]     diff;
	logic                          ge;

	// Half the divisor is added first so the truncating quotient rounds to nearest.
	// Since mag <= den, the top part of the dividend is already below den.
	assign num_full = NumBits'({mag, {FRAC_BITS{1'b0}}}) + NumBits'(den_in >> 1);
	assign trial    = {rem_q, num_q[QuoBits-1]};
	assign diff     = trial - {1'b0, den_q};
	assign ge       = (trial >= {1'b0, den_q});
	assign busy     = busy_q;
	assign quo      = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntBits'(QuoBits);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntBits'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_full[NumBits-1:QuoBits];
			num_q <= num_full[QuoBits-1:0];
			den_q <= den_in;
		end else if (busy_q) begin
			rem_q <= ge ? diff[dda_pkg::MagBits-1:0] : trial[dda_pkg::MagBits-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[QuoBits-2:0], ge};
		end
	end

endmodule

### rtl/dda_back.sv
// ----------------------------------------------------------------------------
// DDA back end
// Steps the line position, runs the increment dividers and builds results.
// ----------------------------------------------------------------------------
module dda_back #(
	parameter int FRAC_BITS = dda_pkg::FracBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dda_pkg::WinBits-1:0] win_w,
	input  logic [dda_pkg::WinBits-1:0] win_h,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  dda_pkg::entry_t             q_data,
	input  logic                        r_full,
	output logic                        r_push,
	output dda_pkg::res_t               r_data
);

	localparam int IntBits  = dda_pkg::CoordBits + 2;
	localparam int PosBits  = IntBits + FRAC_BITS;
	localparam int StepBits = FRAC_BITS + 2;
	localparam int PixBits  = dda_pkg::PixBits;

	logic                          active_q;
	logic                          wait_q;
	logic signed [PosBits-1:0]     pos_x_q;
	logic signed [PosBits-1:0]     pos_y_q;
	logic signed [StepBits-1:0]    step_x_q;
	logic signed [StepBits-1:0]    step_y_q;
	logic [dda_pkg::MagBits-1:0]   steps_left_q;
	logic [dda_pkg::ColorBits-1:0] color_q;
	logic                          neg_x_q;
	logic                          neg_y_q;

	logic                          go;
	logic                          is_start;
	logic                          zero_len;
	logic                          div_start;
	logic                          busy_x;
	logic                          busy_y;
	logic [FRAC_BITS:0]            quo_x;
	logic [FRAC_BITS:0]            quo_y;
	logic signed [StepBits-1:0]    inc_x;
	logic signed [StepBits-1:0]    inc_y;
	logic signed [PosBits-1:0]     start_x;
	logic signed [PosBits-1:0]     start_y;
	logic signed [PosBits-1:0]     next_x;
	logic signed [PosBits-1:0]     next_y;
	logic signed [PosBits-1:0]     emit_x;
	logic signed [PosBits-1:0]     emit_y;
	logic [PixBits:0]              ax;
	logic [PixBits:0]              ay;
	logic                          in_win;

	// Returns {inside, pixel}. The pixel is the position truncated toward zero,
	// so a position just below zero still lands on pixel zero.
	function automatic logic [PixBits:0] axis_pixel(
		input logic signed [PosBits-1:0] p,
		input logic [dda_pkg::WinBits-1:0] lim
	);
		logic signed [IntBits-1:0] ip;
		logic                      fr_nz;
		logic                      ok;
		ip    = IntBits'(p >>> FRAC_BITS);
		fr_nz = |p[FRAC_BITS-1:0];
		if (p[PosBits-1]) begin
			ok = (ip == '1) && fr_nz && (lim != '0);
			return {ok, {PixBits{1'b0}}};
		end
		ok = ($unsigned(ip) < IntBits'(lim));
		return {ok, ip[PixBits-1:0]};
	endfunction

	assign is_start  = (q_data.op == dda_pkg::OpStart);
	assign zero_len  = (q_data.steps == '0);
	assign go        = !q_empty && !r_full && !wait_q;
	assign q_pop     = go;
	assign r_push    = go;
	assign div_start = go && is_start && !zero_len;

	dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (q_data.mag_x),
		.den_in (q_data.steps),
		.busy   (busy_x),
		.quo    (quo_x)
	);

	dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (q_data.mag_y),
		.den_in (q_data.steps),
		.busy   (busy_y),
		.quo    (quo_y)
	);

	assign inc_x = neg_x_q ? -StepBits'({1'b0, quo_x}) : StepBits'({1'b0, quo_x});
	assign inc_y = neg_y_q ? -StepBits'({1'b0, quo_y}) : StepBits'({1'b0, quo_y});

	assign start_x = PosBits'(q_data.sx) <<< FRAC_BITS;
	assign start_y = PosBits'(q_data.sy) <<< FRAC_BITS;
	assign next_x  = pos_x_q + PosBits'(step_x_q);
	assign next_y  = pos_y_q + PosBits'(step_y_q);
	assign emit_x  = is_start ? start_x : next_x;
	assign emit_y  = is_start ? start_y : next_y;
	assign ax      = axis_pixel(emit_x, win_w);
	assign ay      = axis_pixel(emit_y, win_h);
	assign in_win  = ax[PixBits] && ay[PixBits];

	always_comb begin
		r_data = '0;
		if (is_start || active_q) begin
			r_data.pixel_x     = in_win ? ax[PixBits-1:0] : '0;
			r_data.pixel_y     = in_win ? ay[PixBits-1:0] : '0;
			r_data.pixel_color = is_start ? q_data.color : color_q;
			r_data.write_pixel = in_win;
			r_data.last_point  = is_start ? zero_len
				: (steps_left_q == dda_pkg::MagBits'(1));
		end else begin
			r_data.line_idle = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			wait_q   <= 1'b0;
		end else if (go) begin
			if (is_start) begin
				active_q <= !zero_len;
				wait_q   <= !zero_len;
			end else if (active_q && steps_left_q == dda_pkg::MagBits'(1)) begin
				active_q <= 1'b0;
			end
		end else if (wait_q && !busy_x && !busy_y) begin
			wait_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_start) begin
			pos_x_q      <= start_x;
			pos_y_q      <= start_y;
			steps_left_q <= q_data.steps;
			color_q      <= q_data.color;
			neg_x_q      <= q_data.neg_x;
			neg_y_q      <= q_data.neg_y;
		end else if (go && active_q) begin
			pos_x_q      <= next_x;
			pos_y_q      <= next_y;
			steps_left_q <= steps_left_q - 1'b1;
		end
		if (wait_q && !busy_x && !busy_y) begin
			step_x_q <= inc_x;
			step_y_q <= inc_y;
		end
	end

endmodule

### rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Draws lines point by point with fixed-point per-step increments.
// ----------------------------------------------------------------------------
// Channel  Handshake         Payload / width
// command  push / full       cmd   (dda_pkg::cmd_t)
// result   empty / pop       res   (dda_pkg::res_t)
// config   cfg_we            cfg_index (1), cfg_data (13)
//
// Tick items run at one per cycle. A start item with a nonzero length holds the
// back end while the restoring dividers produce the increments, one quotient
// bit per cycle; its first point is issued at once. Reset clears the queues,
// the line state and loads the default window. Input stalls only when the
// front stage and the command queue are full. Apart from the division wait,
// the back end stalls only on a full result queue.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
	parameter int FRAC_BITS = dda_pkg::FracBits,
	parameter int CMD_DEPTH = dda_pkg::CmdDepth
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  dda_pkg::cmd_t               cmd,
	input  logic                        pop,
	output logic                        empty,
	output dda_pkg::res_t               res,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [dda_pkg::WinBits-1:0] cfg_data
);

	logic [dda_pkg::WinBits-1:0] win_w_q;
	logic [dda_pkg::WinBits-1:0] win_h_q;
	logic [dda_pkg::WinBits-1:0] cfg_clamped;

	logic            fq_push;
	logic            fq_full;
	dda_pkg::entry_t fq_in;
	logic            fq_pop;
	logic            fq_empty;
	dda_pkg::entry_t fq_out;

	logic            rq_push;
	logic            rq_full;
	dda_pkg::res_t   rq_in;

	// Windows wider than the pixel field behave as the full field.
	assign cfg_clamped = (cfg_data > dda_pkg::PixLimit) ? dda_pkg::PixLimit : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= dda_pkg::WidthReset;
			win_h_q <= dda_pkg::HeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				dda_pkg::RegWidth: begin
					win_w_q <= cfg_clamped;
				end
				dda_pkg::RegHeight: begin
					win_h_q <= cfg_clamped;
				end
				default: begin
				end
			endcase
		end
	end

	dda_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.q_full (fq_full),
		.q_push (fq_push),
		.q_data (fq_in)
	);

	dda_fifo #(
		.WIDTH ($bits(dda_pkg::entry_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.full     (fq_full),
		.data_in  (fq_in),
		.pop      (fq_pop),
		.empty    (fq_empty),
		.data_out (fq_out)
	);

	dda_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.win_w   (win_w_q),
		.win_h   (win_h_q),
		.q_empty (fq_empty),
		.q_pop   (fq_pop),
		.q_data  (fq_out),
		.r_full  (rq_full),
		.r_push  (rq_push),
		.r_data  (rq_in)
	);

	dda_fifo #(
		.WIDTH ($bits(dda_pkg::res_t)),
		.DEPTH (dda_pkg::ResDepth)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rq_push),
		.full     (rq_full),
		.data_in  (rq_in),
		.pop      (pop),
		.empty    (empty),
		.data_out (res)
	);

endmodule

### rtl/dda_checker.sv
// ----------------------------------------------------------------------------
// DDA result checker
// Port-level checks on the result side of the line rasterizer.
// ----------------------------------------------------------------------------
module dda_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pop,
	input logic          empty,
	input dda_pkg::res_t res
);

	// No item may be waiting on the edge after one where reset was held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("waiting result changed or vanished");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.line_idle |->
			!res.write_pixel && !res.last_point && res.pixel_color == '0)
		else $error("idle item carries point data");

	a_off_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.write_pixel |-> res.pixel_x == '0 && res.pixel_y == '0)
		else $error("unwritten point has nonzero coordinates");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

### dv/dda_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Directed and random line commands are pushed through the command queue under
// several window sizes and idle patterns. A scoreboard predicts every point
// and compares it field by field with what the result queue delivers.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
	import dda_pkg::*;

	localparam int     SettleCycles = 2 * (FracBits + 3) + 8;
	localparam int     CycleLimit   = 500000;
	localparam int     PhaseItems   = 240;
	localparam longint OneFix       = longint'(1) << FracBits;

	class raster_scoreboard;
		logic [WinBits-1:0] win_w;
		logic [WinBits-1:0] win_h;
		longint             pos_x;
		longint             pos_y;
		longint             inc_x;
		longint             inc_y;
		longint             steps_left;
		logic [ColorBits-1:0] line_color;
		bit                 line_active;
		res_t               pending_points[$];
		int                 errors;
		int                 n_checked;

		function new();
			win_w       = WidthReset;
			win_h       = HeightReset;
			pos_x       = 0;
			pos_y       = 0;
			inc_x       = 0;
			inc_y       = 0;
			steps_left  = 0;
			line_color  = '0;
			line_active = 1'b0;
			errors      = 0;
			n_checked   = 0;
		endfunction

		function void set_reg(logic idx, logic [WinBits-1:0] val);
			if (idx == RegWidth) begin
				win_w = val;
			end else begin
				win_h = val;
			end
		endfunction

		function int pending();
			return pending_points.size();
		endfunction

		// Rounded to nearest with ties away from zero; exact ties cannot occur
		// for step counts below 2^17 anyway.
		function longint per_step(longint d, longint n);
			longint a;
			longint q;
			a = (d < 0 ? -d : d) * OneFix;
			q = (a + n / 2) / n;
			return d < 0 ? -q : q;
		endfunction

		function longint to_pixel(longint p);
			if (p < 0) begin
				return -((-p) >> FracBits);
			end
			return p >> FracBits;
		endfunction

		function res_t make_point(bit last);
			res_t   r;
			longint px;
			longint py;
			longint w;
			longint h;
			bit     visible;
			px = to_pixel(pos_x);
			py = to_pixel(pos_y);
			w  = (win_w > PixLimit) ? PixLimit : win_w;
			h  = (win_h > PixLimit) ? PixLimit : win_h;
			visible = px >= 0 && px < w && py >= 0 && py < h;
			r = '0;
			if (visible) begin
				r.pixel_x = px[PixBits-1:0];
				r.pixel_y = py[PixBits-1:0];
			end
			r.pixel_color = line_color;
			r.write_pixel = visible;
			r.last_point  = last;
			r.line_idle   = 1'b0;
			return r;
		endfunction

		function void note_cmd(cmd_t c);
			longint sx;
			longint sy;
			longint dx;
			longint dy;
			longint n;
			res_t   idle_res;
			if (c.opcode == OpStart) begin
				sx = $signed(c.start_x);
				sy = $signed(c.start_y);
				dx = longint'($signed(c.end_x)) - sx;
				dy = longint'($signed(c.end_y)) - sy;
				n  = (dx < 0 ? -dx : dx);
				if ((dy < 0 ? -dy : dy) > n) begin
					n = (dy < 0 ? -dy : dy);
				end
				line_color = c.color;
				pos_x = sx * OneFix;
				pos_y = sy * OneFix;
				if (n == 0) begin
					inc_x       = 0;
					inc_y       = 0;
					steps_left  = 0;
					line_active = 1'b0;
					pending_points.push_back(make_point(1'b1));
				end else begin
					inc_x       = per_step(dx, n);
					inc_y       = per_step(dy, n);
					steps_left  = n;
					line_active = 1'b1;
					pending_points.push_back(make_point(1'b0));
				end
			end else if (!line_active) begin
				idle_res = '0;
				idle_res.line_idle = 1'b1;
				pending_points.push_back(idle_res);
			end else begin
				pos_x = pos_x + inc_x;
				pos_y = pos_y + inc_y;
				steps_left = steps_left - 1;
				if (steps_left == 0) begin
					line_active = 1'b0;
				end
				pending_points.push_back(make_point(steps_left == 0));
			end
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			if (errors <= 50) begin
				$display("ERROR at %0t, result %0d: %s got 0x%0h expected 0x%0h",
					$realtime, n_checked, what, got, want);
			end
		endtask

		task check_point(res_t got);
			res_t want;
			if (pending_points.size() == 0) begin
				report("result with nothing outstanding", longint'(got), 0);
				return;
			end
			want = pending_points.pop_front();
			if (got.pixel_x !== want.pixel_x)
				report("pixel_x", got.pixel_x, want.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				report("pixel_y", got.pixel_y, want.pixel_y);
			if (got.pixel_color !== want.pixel_color)
				report("pixel_color", got.pixel_color, want.pixel_color);
			if (got.write_pixel !== want.write_pixel)
				report("write_pixel", got.write_pixel, want.write_pixel);
			if (got.last_point !== want.last_point)
				report("last_point", got.last_point, want.last_point);
			if (got.line_idle !== want.line_idle)
				report("line_idle", got.line_idle, want.line_idle);
			n_checked++;
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	cmd_t               cmd;
	logic               pop;
	logic               empty;
	res_t               res;
	logic               cfg_we;
	logic               cfg_index;
	logic [WinBits-1:0] cfg_data;

	raster_scoreboard sb;
	int               n_sent;
	int               cycles;
	int               send_idle_pct;
	int               pop_stall_pct;

	dda_line_rasterizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.pop       (pop),
		.empty     (empty),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Results are checked before the command of the same edge is noted, so a
	// point that shows up too early is caught.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_point(res);
			if (push && !full)
				sb.note_cmd(cmd);
		end
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	task send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		cmd  <= c;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n_sent++;
	endtask

	function cmd_t start_cmd(int sx, int sy, int ex, int ey, logic [ColorBits-1:0] col);
		cmd_t c;
		c.opcode  = OpStart;
		c.start_x = 16'(sx);
		c.start_y = 16'(sy);
		c.end_x   = 16'(ex);
		c.end_y   = 16'(ey);
		c.color   = col;
		return c;
	endfunction

	// The coordinate and color fields of a tick carry random values.
	function cmd_t tick_cmd();
		cmd_t c;
		c = start_cmd($urandom, $urandom, $urandom, $urandom, $urandom);
		c.opcode = OpTick;
		return c;
	endfunction

	task wait_drained(int settle);
		push <= 1'b0;
		// Push is dropped and the monitor notes the last accepted item before the pending count is polled.
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task write_window(logic [WinBits-1:0] w, logic [WinBits-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= RegWidth;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= RegHeight;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(RegWidth, w);
		sb.set_reg(RegHeight, h);
	endtask

	function int gen_extent(logic [WinBits-1:0] v);
		if (v == 0)
			return 64;
		return (v > PixLimit) ? int'(PixLimit) : int'(v);
	endfunction

	function int near_border(int extent);
		case ($urandom_range(3))
			0: return -1;
			1: return 0;
			2: return extent - 1;
			default: return extent;
		endcase
	endfunction

	task run_directed();
		send_cmd(start_cmd(0, 0, 0, 0, 32'hFFFF_FFFF));
		send_cmd(tick_cmd());
		send_cmd(start_cmd(0, 0, 3, 1, 32'h1234_5678));
		repeat (4) send_cmd(tick_cmd());
		// Negative positions truncate toward zero.
		send_cmd(start_cmd(5, 5, -2, 1, 32'h0F0F_F0F0));
		repeat (7) send_cmd(tick_cmd());
		// This line is abandoned by the following start while still in progress.
		send_cmd(start_cmd(10, 10, 20, 30, 32'h00C0_FFEE));
		send_cmd(tick_cmd());
		send_cmd(start_cmd(1023, 767, 1024, 768, 32'h8000_0001));
		send_cmd(tick_cmd());
		send_cmd(start_cmd(-32768, -32768, 32767, 32767, 32'h0));
		repeat (2) send_cmd(tick_cmd());
		send_cmd(start_cmd(32767, -32768, -32768, 32767, 32'hA5A5_A5A5));
		send_cmd(tick_cmd());
		send_cmd(start_cmd(-1, -1, -1, -1, 32'h5A5A_5A5A));
	endtask

	// Mostly complete short lines near the window, plus cut-short and overrun
	// lines, full-range lines and stray ticks.
	task random_phase(int n_items);
		int goal;
		int gw;
		int gh;
		int sx;
		int sy;
		int ex;
		int ey;
		int len;
		int steps;
		int nt;
		int pick;
		goal = n_sent + n_items;
		gw = gen_extent(sb.win_w);
		gh = gen_extent(sb.win_h);
		while (n_sent < goal) begin
			if ($urandom_range(299) == 0)
				wait_drained(0);
			pick = $urandom_range(99);
			if (pick < 78) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
				if ($urandom_range(4) == 0) begin
					sx = near_border(gw);
					sy = near_border(gh);
				end else begin
					sx = int'($urandom_range(gw + 16)) - 8;
					sy = int'($urandom_range(gh + 16)) - 8;
				end
				ex = sx + int'($urandom_range(2 * len)) - len;
				ey = sy + int'($urandom_range(2 * len)) - len;
				steps = (ex > sx) ? ex - sx : sx - ex;
				if (((ey > sy) ? ey - sy : sy - ey) > steps)
					steps = (ey > sy) ? ey - sy : sy - ey;
				nt = steps;
				case ($urandom_range(9))
					0: nt = $urandom_range(steps);
					1: nt = steps + $urandom_range(2, 1);
					default: ;
				endcase
				send_cmd(start_cmd(sx, sy, ex, ey, $urandom));
				repeat (nt) send_cmd(tick_cmd());
			end else if (pick < 88) begin
				send_cmd(start_cmd($urandom, $urandom, $urandom, $urandom, $urandom));
				repeat ($urandom_range(5)) send_cmd(tick_cmd());
			end else begin
				send_cmd(tick_cmd());
			end
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		push          = 1'b0;
		cmd           = '0;
		pop           = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = RegWidth;
		cfg_data      = '0;
		n_sent        = 0;
		cycles        = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained(SettleCycles);
			case (ph)
				0: write_window(13'd4096, 13'd4096);
				1: write_window(13'd1, 13'd1);
				2: write_window(13'd0, 13'd0);
				3: write_window(13'h1FFF, 13'h1FFF);
				4: write_window(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
				5: write_window(13'($urandom), 13'($urandom));
				6: write_window(13'd4096, 13'd1);
				default: write_window(WidthReset, HeightReset);
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					pop_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					pop_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					pop_stall_pct = 55;
				end
				default: begin
					send_idle_pct = 31;
					pop_stall_pct = 31;
				end
			endcase
			random_phase(PhaseItems);
		end

		wait_drained(SettleCycles);
		if (sb.pending() != 0)
			sb.report("points never delivered", sb.pending(), 0);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
